// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the NAND page read sequencer checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define NPRS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Same, on the module's own aclk and aresetn.
`define NPRS_ASSERT_CLK(label, prop, msg) \
    `NPRS_ASSERT(label, aclk, aresetn, prop, msg)

`endif

// ----- hw/rtl/nprs_pkg.sv -----
// ----------------------------------------------------------------------------
// nprs_pkg
// Types and constants shared by the NAND page read sequencer and its checker.
// ----------------------------------------------------------------------------
package nprs_pkg;

    // Flash bus operation reported with every result item
    typedef enum logic [2:0] {
        OP_NONE     = 3'd0,
        OP_SELECT   = 3'd1,
        OP_CMD      = 3'd2,
        OP_ADDR     = 3'd3,
        OP_WAIT     = 3'd4,
        OP_DATA     = 3'd5,
        OP_DESELECT = 3'd6
    } bus_op_t;

    // Item kinds on the input channel
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    // Large-page read commands
    localparam logic [7:0] CMD_READ    = 8'h00;
    localparam logic [7:0] CMD_CONFIRM = 8'h30;

    // Five address bytes per page access
    localparam logic [2:0] ADDR_LAST_CYCLE = 3'd4;

    localparam int unsigned S_TDATA_W = 80;
    localparam int unsigned M_TDATA_W = 48;
    localparam int unsigned M_TUSER_W = 4;

endpackage

// ----- hw/rtl/nand_page_read_sequencer.sv -----
// ----------------------------------------------------------------------------
// nand_page_read_sequencer
// Steps a large-page NAND flash through select, read command, five address
// bytes, confirm, ready wait and data reads, page by page, then deselect.
// ----------------------------------------------------------------------------
// A start item (s_tuser = 0) loads a byte address and a length and answers
// with a "none" item. Every following step item (s_tuser = 1) produces one
// bus operation: select, command 0x00, column low/high, page bytes 0..2,
// command 0x30, wait until ready_req is seen high, then one data read per
// step up to the end of the page or the request; the next page starts again
// at the read command with column zero, and a deselect with m_tlast set ends
// the request. A zero length gives select and then deselect. Every item gives
// exactly one result item. The block takes one item per clock: the state
// update and the result are computed in one pass from the accepted item into
// the output register, and a new item is taken whenever that register is
// empty or is being drained in the same cycle. PAGE_BYTES must be a power
// of two (512 to 16384); the column is the low address bits and the page
// number is the address shifted right.
// ----------------------------------------------------------------------------
module nand_page_read_sequencer #(
    parameter int unsigned PAGE_BYTES = 2048
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: start_address[31:0], length[63:32], ready_req[64],
    //          data_in[72:65], zero fill[79:73]
    input  logic [nprs_pkg::S_TDATA_W-1:0]      s_tdata,
    // s_tuser: action[0]
    input  logic [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: bus_value[7:0], data_byte[15:8], byte_index[47:16]
    output logic [nprs_pkg::M_TDATA_W-1:0]      m_tdata,
    // m_tuser: bus_op[2:0], data_valid[3]
    output logic [nprs_pkg::M_TUSER_W-1:0]      m_tuser,
    // m_tlast: done_res
    output logic                                m_tlast
);

    localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam logic [31:0] COL_MASK   = 32'(PAGE_BYTES - 1);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_SELECT,
        PH_CMD_READ,
        PH_ADDR,
        PH_CMD_CONFIRM,
        PH_WAIT,
        PH_DATA,
        PH_DESELECT
    } phase_t;

    // Sequencer state
    phase_t        phase_reg, phase_next;
    logic [31:0]   addr_reg, addr_next;
    logic [31:0]   done_cnt_reg, done_cnt_next;
    logic [31:0]   total_reg, total_next;
    logic [2:0]    acyc_reg, acyc_next;

    // Output register
    logic              m_valid_reg, m_valid_next;
    nprs_pkg::bus_op_t op_reg, op_next;
    logic [7:0]        value_reg, value_next;
    logic              dvalid_reg, dvalid_next;
    logic [7:0]        dbyte_reg, dbyte_next;
    logic [31:0]       index_reg, index_next;
    logic              done_reg, done_next;

    // Input fields
    logic        in_action;
    logic [31:0] in_start_address;
    logic [31:0] in_length;
    logic        in_ready;
    logic [7:0]  in_data;

    logic        take;
    logic [31:0] column;
    logic [31:0] page;
    logic [31:0] addr_inc;
    logic [31:0] done_inc;
    logic [7:0]  addr_byte;

    assign in_action        = s_tuser[0];
    assign in_start_address = s_tdata[31:0];
    assign in_length        = s_tdata[63:32];
    assign in_ready         = s_tdata[64];
    assign in_data          = s_tdata[72:65];

    // Take a new item whenever the output register frees up this cycle
    assign s_tready = aresetn && (!m_valid_reg || m_tready);
    assign take     = s_tvalid && s_tready;

    assign column   = addr_reg & COL_MASK;
    assign page     = addr_reg >> PAGE_SHIFT;
    assign addr_inc = addr_reg + 32'd1;
    assign done_inc = done_cnt_reg + 32'd1;

    // Column bytes first, then the three low page bytes
    always_comb begin
        case (acyc_reg)
            3'd0:    addr_byte = column[7:0];
            3'd1:    addr_byte = column[15:8];
            3'd2:    addr_byte = page[7:0];
            3'd3:    addr_byte = page[15:8];
            default: addr_byte = page[23:16];
        endcase
    end

    always_comb begin
        phase_next    = phase_reg;
        addr_next     = addr_reg;
        done_cnt_next = done_cnt_reg;
        total_next    = total_reg;
        acyc_next     = acyc_reg;

        op_next     = op_reg;
        value_next  = value_reg;
        dvalid_next = dvalid_reg;
        dbyte_next  = dbyte_reg;
        index_next  = index_reg;
        done_next   = done_reg;

        // Drop the held result once taken
        m_valid_next = m_valid_reg && !m_tready;

        if (take) begin
            m_valid_next = 1'b1;
            op_next      = nprs_pkg::OP_NONE;
            value_next   = 8'd0;
            dvalid_next  = 1'b0;
            dbyte_next   = 8'd0;
            index_next   = 32'd0;
            done_next    = 1'b0;

            if (in_action == nprs_pkg::ACT_START) begin
                // Abandon any active request and load the new one
                addr_next     = in_start_address;
                total_next    = in_length;
                done_cnt_next = 32'd0;
                acyc_next     = 3'd0;
                phase_next    = PH_SELECT;
            end else begin
                unique case (phase_reg)
                    PH_IDLE: begin
                        phase_next = PH_IDLE;
                    end
                    PH_SELECT: begin
                        op_next    = nprs_pkg::OP_SELECT;
                        phase_next = (total_reg == 32'd0) ? PH_DESELECT : PH_CMD_READ;
                    end
                    PH_CMD_READ: begin
                        op_next    = nprs_pkg::OP_CMD;
                        value_next = nprs_pkg::CMD_READ;
                        acyc_next  = 3'd0;
                        phase_next = PH_ADDR;
                    end
                    PH_ADDR: begin
                        op_next    = nprs_pkg::OP_ADDR;
                        value_next = addr_byte;
                        if (acyc_reg >= nprs_pkg::ADDR_LAST_CYCLE) begin
                            acyc_next  = 3'd0;
                            phase_next = PH_CMD_CONFIRM;
                        end else begin
                            acyc_next = acyc_reg + 3'd1;
                        end
                    end
                    PH_CMD_CONFIRM: begin
                        op_next    = nprs_pkg::OP_CMD;
                        value_next = nprs_pkg::CMD_CONFIRM;
                        phase_next = PH_WAIT;
                    end
                    PH_WAIT: begin
                        // Hold in wait until the flash reports ready
                        op_next = nprs_pkg::OP_WAIT;
                        if (in_ready) begin
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        op_next       = nprs_pkg::OP_DATA;
                        dvalid_next   = 1'b1;
                        dbyte_next    = in_data;
                        index_next    = done_cnt_reg;
                        done_cnt_next = done_inc;
                        addr_next     = addr_inc;
                        if (done_inc == total_reg) begin
                            phase_next = PH_DESELECT;
                        end else if ((addr_inc & COL_MASK) == 32'd0) begin
                            // Page boundary: reissue the read at column zero
                            phase_next = PH_CMD_READ;
                        end
                    end
                    PH_DESELECT: begin
                        op_next    = nprs_pkg::OP_DESELECT;
                        done_next  = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        value_reg    <= value_next;
        dvalid_reg   <= dvalid_next;
        dbyte_reg    <= dbyte_next;
        index_reg    <= index_next;
        done_reg     <= done_next;
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            m_valid_reg  <= 1'b0;
            addr_reg     <= 32'd0;
            done_cnt_reg <= 32'd0;
            total_reg    <= 32'd0;
            acyc_reg     <= 3'd0;
        end else begin
            phase_reg    <= phase_next;
            m_valid_reg  <= m_valid_next;
            addr_reg     <= addr_next;
            done_cnt_reg <= done_cnt_next;
            total_reg    <= total_next;
            acyc_reg     <= acyc_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {index_reg, dbyte_reg, value_reg};
    assign m_tuser  = {dvalid_reg, op_reg};
    assign m_tlast  = done_reg;

endmodule

// ----- hw/rtl/nprs_checker.sv -----
// ----------------------------------------------------------------------------
// nprs_checker
// Port-level checks on the NAND page read sequencer, bound into each instance.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nprs_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [0:0]                      s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [nprs_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [nprs_pkg::M_TUSER_W-1:0]  m_tuser,
    input logic                            m_tlast
);

    `NPRS_ASSERT(a_out_hold, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser),
        "result item changed while stalled")

    `NPRS_ASSERT(a_start_none, aclk, aresetn,
        s_tvalid && s_tready && (s_tuser[0] == nprs_pkg::ACT_START)
            |=> m_tvalid && (m_tuser[2:0] == nprs_pkg::OP_NONE),
        "start item did not answer with a none operation")

    `NPRS_ASSERT_CLK(a_data_flag,
        m_tvalid |-> (m_tuser[3] == (m_tuser[2:0] == nprs_pkg::OP_DATA)),
        "data_valid disagrees with the data read operation")

    `NPRS_ASSERT_CLK(a_last_deselect,
        m_tvalid && m_tlast |-> (m_tuser[2:0] == nprs_pkg::OP_DESELECT),
        "done flagged on an operation other than deselect")

endmodule

bind nand_page_read_sequencer nprs_checker u_nprs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- tb/sv/nprs_sequence_checker.sv -----
// ----------------------------------------------------------------------------
// nprs_sequence_checker
// Watches both channels of the NAND page read sequencer, predicts the bus
// operation that each accepted input item must produce and compares every
// accepted result item against the oldest prediction.
// ----------------------------------------------------------------------------
module nprs_sequence_checker #(
    parameter int unsigned PAGE_BYTES = 2048
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [nprs_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [0:0]                      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [nprs_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic [nprs_pkg::M_TUSER_W-1:0]  m_tuser,
    input  logic                            m_tlast,
    output int                              mismatches,
    output int                              outstanding
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_SELECT,
        PH_CMD_READ,
        PH_ADDR,
        PH_CMD_CONFIRM,
        PH_WAIT,
        PH_DATA,
        PH_DESELECT
    } seq_phase_t;

    typedef struct packed {
        nprs_pkg::bus_op_t op;
        logic [7:0]        value;
        logic              valid;
        logic [7:0]        dbyte;
        logic [31:0]       idx;
        logic              done;
    } flash_bus_item_t;

    seq_phase_t      seq_phase;
    logic [31:0]     flash_addr;
    logic [31:0]     bytes_sent;
    logic [31:0]     request_len;
    logic [14:0]     page_column;
    logic [2:0]      addr_byte_sel;
    flash_bus_item_t bus_ops_expected[$];

    // Advance the sequencer by one input item and return the bus operation.
    function automatic flash_bus_item_t step_sequencer(input logic act,
                                                       input logic [31:0] addr,
                                                       input logic [31:0] len,
                                                       input logic rdy,
                                                       input logic [7:0] din);
        flash_bus_item_t r;
        logic [31:0]     page;
        r = '0;
        r.op = nprs_pkg::OP_NONE;
        page = flash_addr / PAGE_BYTES;
        if (act == nprs_pkg::ACT_START) begin
            flash_addr    = addr;
            request_len   = len;
            bytes_sent    = '0;
            page_column   = 15'(addr % PAGE_BYTES);
            addr_byte_sel = '0;
            seq_phase     = PH_SELECT;
        end else begin
            case (seq_phase)
                PH_SELECT: begin
                    r.op = nprs_pkg::OP_SELECT;
                    seq_phase = (request_len == 0) ? PH_DESELECT : PH_CMD_READ;
                end
                PH_CMD_READ: begin
                    r.op = nprs_pkg::OP_CMD;
                    r.value = nprs_pkg::CMD_READ;
                    addr_byte_sel = '0;
                    seq_phase = PH_ADDR;
                end
                PH_ADDR: begin
                    r.op = nprs_pkg::OP_ADDR;
                    case (addr_byte_sel)
                        3'd0:    r.value = page_column[7:0];
                        3'd1:    r.value = {1'b0, page_column[14:8]};
                        3'd2:    r.value = page[7:0];
                        3'd3:    r.value = page[15:8];
                        default: r.value = page[23:16];
                    endcase
                    if (addr_byte_sel >= nprs_pkg::ADDR_LAST_CYCLE) begin
                        addr_byte_sel = '0;
                        seq_phase = PH_CMD_CONFIRM;
                    end else begin
                        addr_byte_sel = addr_byte_sel + 3'd1;
                    end
                end
                PH_CMD_CONFIRM: begin
                    r.op = nprs_pkg::OP_CMD;
                    r.value = nprs_pkg::CMD_CONFIRM;
                    seq_phase = PH_WAIT;
                end
                PH_WAIT: begin
                    r.op = nprs_pkg::OP_WAIT;
                    if (rdy) seq_phase = PH_DATA;
                end
                PH_DATA: begin
                    r.op    = nprs_pkg::OP_DATA;
                    r.valid = 1'b1;
                    r.dbyte = din;
                    r.idx   = bytes_sent;
                    bytes_sent  = bytes_sent + 32'd1;
                    flash_addr  = flash_addr + 32'd1;
                    page_column = page_column + 15'd1;
                    if (bytes_sent == request_len) begin
                        seq_phase = PH_DESELECT;
                    end else if (page_column >= PAGE_BYTES) begin
                        page_column = '0;
                        seq_phase = PH_CMD_READ;
                    end
                end
                PH_DESELECT: begin
                    r.op   = nprs_pkg::OP_DESELECT;
                    r.done = 1'b1;
                    seq_phase = PH_IDLE;
                end
                default: seq_phase = PH_IDLE;
            endcase
        end
        return r;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    always @(posedge aclk) begin
        flash_bus_item_t want;
        if (!aresetn) begin
            seq_phase     = PH_IDLE;
            flash_addr    = '0;
            bytes_sent    = '0;
            request_len   = '0;
            page_column   = '0;
            addr_byte_sel = '0;
            bus_ops_expected.delete();
        end else begin
            // Retire the result first: it always belongs to an earlier item.
            if (m_tvalid && m_tready) begin
                if (bus_ops_expected.size() == 0) begin
                    $display("%0t: result item with nothing expected, got op %0d", $time,
                             m_tuser[2:0]);
                    mismatches++;
                end else begin
                    want = bus_ops_expected.pop_front();
                    check_field("bus_op", 32'(want.op), 32'(m_tuser[2:0]));
                    check_field("bus_value", 32'(want.value), 32'(m_tdata[7:0]));
                    check_field("data_valid", 32'(want.valid), 32'(m_tuser[3]));
                    check_field("data_byte", 32'(want.dbyte), 32'(m_tdata[15:8]));
                    check_field("byte_index", want.idx, m_tdata[47:16]);
                    check_field("done", 32'(want.done), 32'(m_tlast));
                end
            end
            if (s_tvalid && s_tready)
                bus_ops_expected.push_back(step_sequencer(s_tuser[0], s_tdata[31:0],
                                                          s_tdata[63:32], s_tdata[64],
                                                          s_tdata[72:65]));
        end
        outstanding = bus_ops_expected.size();
    end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives read requests and flash bus steps into the NAND page read sequencer
// with bursty input and a stalling receiver; a checker beside the block
// predicts and compares every result item.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned PAGE_BYTES  = 2048;
    localparam int          ITEM_TARGET = 1580;
    localparam int          IDLE_LIMIT  = 3000;

    logic                                aclk;
    logic                                aresetn;
    logic                                s_tvalid;
    logic                                s_tready;
    // s_tdata: start_address[31:0], length[63:32], ready_req[64],
    //          data_in[72:65], zero fill[79:73]
    logic [nprs_pkg::S_TDATA_W-1:0]      s_tdata;
    // s_tuser: action[0]
    logic [0:0]                          s_tuser;
    logic                                m_tvalid;
    logic                                m_tready;
    // m_tdata: bus_value[7:0], data_byte[15:8], byte_index[47:16]
    logic [nprs_pkg::M_TDATA_W-1:0]      m_tdata;
    // m_tuser: bus_op[2:0], data_valid[3]
    logic [nprs_pkg::M_TUSER_W-1:0]      m_tuser;
    logic                                m_tlast;

    int mismatches;
    int outstanding;
    int items_sent;
    int burst_left;
    int idle_cycles;

    nand_page_read_sequencer #(
        .PAGE_BYTES (PAGE_BYTES)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    nprs_sequence_checker #(
        .PAGE_BYTES (PAGE_BYTES)
    ) i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Offer one item at the falling edge and hold it until it is accepted.
    // Drop valid for a random gap whenever the current burst runs out.
    task automatic send_item(input logic act, input logic [31:0] addr,
                             input logic [31:0] len, input logic rdy,
                             input logic [7:0] din);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 10);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
            // Mostly short bursts, now and then a long stretch without gaps
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {7'b0, din, rdy, len, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        items_sent++;
    endtask

    // Bus step; the request fields are ignored here, so fill them at random.
    task automatic send_step(input logic rdy, input logic [7:0] din);
        send_item(nprs_pkg::ACT_STEP, $urandom, $urandom, rdy, din);
    endtask

    // Hold the input until every predicted result has come back.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    // Start a request and walk it through its legal bus steps: select,
    // then per page read command, five address bytes, confirm, any busy
    // waits, the ready wait and the data reads, then deselect. Stop early after
    // step_limit steps, which leaves the request abandoned for the next start.
    task automatic run_request(input logic [31:0] addr, input logic [31:0] len,
                               input int step_limit);
        logic        ready_plan[$];
        logic [31:0] left;
        int          col;
        int          chunk;
        int          n;
        send_item(nprs_pkg::ACT_START, addr, len, 1'($urandom_range(0, 1)), 8'($urandom));
        ready_plan.push_back(1'($urandom_range(0, 1)));
        left = len;
        col  = addr % PAGE_BYTES;
        while (left != 0 && ready_plan.size() < step_limit) begin
            repeat (7) ready_plan.push_back(1'($urandom_range(0, 1)));
            while ($urandom_range(0, 2) == 0) ready_plan.push_back(1'b0);
            ready_plan.push_back(1'b1);
            chunk = ((PAGE_BYTES - col) < left) ? (PAGE_BYTES - col) : left;
            if (chunk > step_limit) chunk = step_limit;
            repeat (chunk) ready_plan.push_back(1'($urandom_range(0, 1)));
            left = left - chunk;
            col  = 0;
        end
        ready_plan.push_back(1'($urandom_range(0, 1)));
        n = (ready_plan.size() < step_limit) ? ready_plan.size() : step_limit;
        for (int i = 0; i < n; i++) send_step(ready_plan[i], 8'($urandom));
    endtask

    // Receiver: switch stall pattern every so often, and once hold off
    // for a long stretch while the sender keeps offering items.
    initial begin : receiver
        int rx_cycles;
        int mode;
        rx_cycles = 0;
        mode      = 0;
        m_tready  = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            rx_cycles++;
            if (rx_cycles % 150 == 0) mode = $urandom_range(0, 3);
            if (rx_cycles == 1200) begin
                m_tready <= 1'b0;
                repeat (120) @(negedge aclk);
                rx_cycles += 120;
            end else begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 4) == 0);
                    default: m_tready <= (rx_cycles % 4 != 3);
                endcase
            end
        end
    end

    // Watchdog: give up when nothing moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int          kind;
        int          next_drain;
        logic [31:0] addr;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tuser     = nprs_pkg::ACT_STEP;
        s_tdata     = '0;
        items_sent  = 0;
        burst_left  = 0;
        idle_cycles = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Step with no request loaded: expect an empty operation
        send_step(1'b1, 8'hff);
        // Zero length at the top address: select, then deselect at once
        send_item(nprs_pkg::ACT_START, '1, '0, 1'b0, 8'h00);
        send_step(1'b0, 8'h00);
        send_step(1'b1, 8'h5a);
        // Full length at the last byte of flash: select, read command,
        // address bytes ff 07 ff ff 1f, confirm, one busy wait, then one data read
        // that wraps the address to zero, then the read command of the next page
        send_item(nprs_pkg::ACT_START, '1, '1, 1'b1, 8'hff);
        repeat (8) send_step(1'b1, 8'($urandom));
        send_step(1'b0, 8'h00);
        send_step(1'b1, 8'h00);
        send_step(1'b0, 8'hff);
        send_step(1'b1, 8'h00);
        // Abandon it with a one-byte read at address zero, through to deselect
        send_item(nprs_pkg::ACT_START, '0, 32'd1, 1'b0, 8'h00);
        repeat (8) send_step(1'b0, 8'($urandom));
        send_step(1'b1, 8'($urandom));
        send_step(1'b0, 8'h00);
        send_step(1'b1, 8'h81);
        drain_results();

        next_drain = items_sent + 300;
        while (items_sent < ITEM_TARGET) begin
            kind = $urandom_range(0, 99);
            addr = $urandom;
            if (kind < 50) begin
                run_request(addr, $urandom_range(1, 24), 1 << 30);
            end else if (kind < 65) begin
                // Start 1 to 8 bytes before a page end so the read can spill over
                addr = (($urandom_range(0, 7) == 0) ? 32'hffff_ffff : addr);
                addr = addr - (addr % PAGE_BYTES) + PAGE_BYTES - $urandom_range(1, 8);
                run_request(addr, $urandom_range(2, 20), 1 << 30);
            end else if (kind < 72) begin
                run_request(addr, '0, 1 << 30);
            end else if (kind < 80) begin
                run_request(addr, $urandom_range(40, 200), 1 << 30);
            end else if (kind < 90) begin
                run_request(addr, $urandom, $urandom_range(0, 30));
            end else begin
                repeat ($urandom_range(1, 3))
                    send_step(1'($urandom_range(0, 1)), 8'($urandom));
            end
            if (items_sent >= next_drain) begin
                drain_results();
                next_drain = items_sent + 300;
            end
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/nprs_pkg.sv
hw/rtl/nand_page_read_sequencer.sv
hw/rtl/nprs_checker.sv
tb/sv/nprs_sequence_checker.sv
tb/sv/testbench.sv
